// ----- hdl/apq_pkg.sv -----
// Package for the array max-priority queue: sizes, command and status codes,
// and the memory request type. No dependencies.
package apq_pkg;

    localparam int DEPTH = 16;
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CAP_W = 5;
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELMAX = 2'd1;
    localparam logic [1:0] CMD_DUMP   = 2'd2;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    typedef logic [31:0] t_word;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_word            wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// ----- hdl/apq_ram.sv -----
// Entry storage of the priority queue: one write port, one read port with
// registered read data. Depends on apq_pkg.
module apq_ram (
    input  logic              i_clk,
    input  apq_pkg::t_ram_req i_req,
    output apq_pkg::t_word    o_rdata
);
    import apq_pkg::*;

    t_word r_mem [DEPTH];
    t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hdl/array_max_priority_queue_unit.sv -----
// Top level of the array max-priority queue: command sequencer, count and
// capacity registers, output register. Depends on apq_pkg and apq_ram.
//
// Usage: commands enter on the input channel (i_in_valid / o_in_stall) with
// i_command and i_value; results leave on the output channel (o_out_valid /
// i_out_stall) as o_status, o_value_res and o_last. Each command is worked
// on alone; o_in_stall is high from acceptance until its final result has
// been loaded into the output register.
// Steps, with N entries held and the maximum found at index B:
//   insert          entry written at acceptance, result from S_EMIT.
//   delete largest  scan of all N entries (S_SREAD, S_SCMP each), shift-down
//                   of the N-1-B entries above B (S_SHREAD, S_SHWR), S_EMIT.
//   dump            S_DREAD then S_DEMIT per entry, one result per entry.
//   empty queue     one empty result from S_EMIT.
// These steps are set by the single read port of the entry memory, whose
// read data is registered and arrives in the cycle after the address.
// A stall on the output side holds the result in the output register and
// the sequencer waits for it to drain. Reset clears the count, the output
// valid and the sequencer and sets the capacity to 16; entry contents are
// not cleared, since only entries below the count are ever read.
// Capacity is written through i_cfg_we / i_cfg_data; the user must write it only while the block is idle,
// as the block itself does not enforce this. Values above the memory depth act as the depth.
module array_max_priority_queue_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [apq_pkg::CAP_W-1:0] i_cfg_data,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [1:0]                i_command,
    input  apq_pkg::t_word            i_value,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [1:0]                o_status,
    output apq_pkg::t_word            o_value_res,
    output logic                      o_last
);
    import apq_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EMIT   = 3'd1;
    localparam logic [2:0] S_SREAD  = 3'd2;
    localparam logic [2:0] S_SCMP   = 3'd3;
    localparam logic [2:0] S_SHREAD = 3'd4;
    localparam logic [2:0] S_SHWR   = 3'd5;
    localparam logic [2:0] S_DREAD  = 3'd6;
    localparam logic [2:0] S_DEMIT  = 3'd7;

    logic [2:0]       r_state;
    logic [CNT_W-1:0] r_count;
    logic [CAP_W-1:0] r_cap;
    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] r_best_idx;
    t_word            r_best;
    logic [1:0]       r_pend_status;
    t_word            r_pend_value;

    logic             r_out_valid;
    logic [1:0]       r_status;
    t_word            r_value;
    logic             r_last;

    t_ram_req         ram_req;
    t_word            rdata;

    logic             accept;
    logic             out_free;
    logic             out_load;
    logic             full;
    logic             ptr_is_last;
    logic             shift_done;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;

    apq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (ram_req),
        .o_rdata (rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    // A result is loaded into the output register in this cycle.
    assign out_load   = out_free && ((r_state == S_EMIT) || (r_state == S_DEMIT));

    // Capacity above the memory depth behaves as the depth.
    assign cap_ext = CMP_W'(r_cap);
    assign eff_cap = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;
    assign full    = CMP_W'(r_count) >= eff_cap;

    assign ptr_is_last = (CNT_W'(r_ptr) + CNT_W'(1)) == r_count;
    // The shift is over once the pointer sits on the last occupied entry.
    assign shift_done  = ptr_is_last;

    always_comb begin
        ram_req = '0;
        case (r_state)
            S_IDLE: begin
                if (accept && (i_command == CMD_INSERT) && !full) begin
                    ram_req.we    = 1'b1;
                    ram_req.waddr = IDX_W'(r_count);
                    ram_req.wdata = i_value;
                end
            end
            S_SREAD, S_DREAD: begin
                ram_req.re    = 1'b1;
                ram_req.raddr = r_ptr;
            end
            S_SHREAD: begin
                if (!shift_done) begin
                    ram_req.re    = 1'b1;
                    ram_req.raddr = r_ptr + IDX_W'(1);
                end
            end
            S_SHWR: begin
                ram_req.we    = 1'b1;
                ram_req.waddr = r_ptr;
                ram_req.wdata = rdata;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cap       <= CAP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (r_out_valid && !i_out_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_ptr <= '0;
                        case (i_command)
                            CMD_INSERT: begin
                                r_pend_value <= i_value;
                                r_state      <= S_EMIT;
                                if (full) begin
                                    r_pend_status <= ST_FULL;
                                end else begin
                                    r_pend_status <= ST_OK;
                                    r_count       <= r_count + CNT_W'(1);
                                end
                            end
                            CMD_DELMAX, CMD_DUMP: begin
                                if (r_count == '0) begin
                                    r_pend_status <= ST_EMPTY;
                                    r_pend_value  <= '0;
                                    r_state       <= S_EMIT;
                                end else if (i_command == CMD_DELMAX) begin
                                    r_state <= S_SREAD;
                                end else begin
                                    r_state <= S_DREAD;
                                end
                            end
                            default: begin
                                // Unused command code: no result, queue unchanged.
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_status    <= r_pend_status;
                        r_value     <= r_pend_value;
                        r_last      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                S_SREAD: begin
                    r_state <= S_SCMP;
                end
                S_SCMP: begin
                    // Strictly greater only, so the earliest entry wins a tie.
                    if ((r_ptr == '0) || ($signed(rdata) > $signed(r_best))) begin
                        r_best     <= rdata;
                        r_best_idx <= r_ptr;
                    end
                    if (ptr_is_last) begin
                        r_ptr   <= (r_ptr == '0) || ($signed(rdata) > $signed(r_best))
                                   ? r_ptr : r_best_idx;
                        r_state <= S_SHREAD;
                    end else begin
                        r_ptr   <= r_ptr + IDX_W'(1);
                        r_state <= S_SREAD;
                    end
                end
                S_SHREAD: begin
                    if (shift_done) begin
                        r_count       <= r_count - CNT_W'(1);
                        r_pend_status <= ST_OK;
                        r_pend_value  <= r_best;
                        r_state       <= S_EMIT;
                    end else begin
                        r_state <= S_SHWR;
                    end
                end
                S_SHWR: begin
                    r_ptr   <= r_ptr + IDX_W'(1);
                    r_state <= S_SHREAD;
                end
                S_DREAD: begin
                    r_state <= S_DEMIT;
                end
                S_DEMIT: begin
                    // Read data holds here since no new read is issued.
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_status    <= ST_OK;
                        r_value     <= rdata;
                        r_last      <= ptr_is_last;
                        if (ptr_is_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_ptr   <= r_ptr + IDX_W'(1);
                            r_state <= S_DREAD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_status;
    assign o_value_res = r_value;
    assign o_last      = r_last;

endmodule
